### hdl/event_timing_statistics_table_assert.svh
// ----------------------------------------------------------------------------
// event_timing_statistics_table_assert
// Assertion helpers shared by the event timing statistics table modules.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni in scope.
`ifndef EVENT_TIMING_STATISTICS_TABLE_ASSERT_SVH
`define EVENT_TIMING_STATISTICS_TABLE_ASSERT_SVH

// Same-cycle implication.
`define ETST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ETST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/etst_pkg.sv
// ----------------------------------------------------------------------------
// etst_pkg
// Shared types, constants and the sample update function of the event
// timing statistics table.
// ----------------------------------------------------------------------------
package etst_pkg;

  localparam int WORKER_COUNT = 8;
  localparam int SLOT_COUNT   = 64;
  localparam int TIME_BITS    = 48;
  localparam int WORKER_W     = 3;
  localparam int SLOT_W       = 6;
  localparam int KIND_W       = 4;
  localparam int STAT_W       = 64;
  localparam int CNT_W        = 32;

  localparam logic [STAT_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    K_CLEAR       = 4'd0,
    K_RUN_BEGIN   = 4'd1,
    K_PHASE_BEGIN = 4'd2,
    K_PHASE_END   = 4'd3,
    K_RUN_END     = 4'd4,
    K_TASK_BEGIN  = 4'd5,
    K_INNER_BEGIN = 4'd6,
    K_INNER_END   = 4'd7,
    K_TASK_END    = 4'd8,
    K_FINALIZE    = 4'd9,
    K_READ        = 4'd10
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FGRP,
    S_FWAIT,
    S_FWB,
    S_FRD,
    S_FLD
  } ctrl_state_e;

  // One statistic group: sum (or average), minimum, maximum
  typedef struct packed {
    logic [STAT_W-1:0] sum_v;
    logic [STAT_W-1:0] min_v;
    logic [STAT_W-1:0] max_v;
  } stat_t;

  // Group 0 total, group 1 inner, group 2 overhead
  typedef struct packed {
    stat_t [2:0]      grp;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // One task row: statistics plus the inner begin and end marks
  typedef struct packed {
    entry_t               ent;
    logic [TIME_BITS-1:0] ib;
    logic [TIME_BITS-1:0] ie;
  } row_t;

  localparam stat_t  STAT_RESET  = '{sum_v: '0, min_v: INT64_MAX, max_v: '0};
  localparam entry_t ENTRY_RESET = '{grp: {STAT_RESET, STAT_RESET, STAT_RESET}, cnt: '0};
  localparam row_t   ROW_RESET   = '{ent: ENTRY_RESET, ib: '0, ie: '0};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              latch;
    logic              rd_en;
    logic              rd_fin;
    logic              exec;
    logic              ent_run;
    logic              ent_mem;
    logic              zero_min;
    logic              div_start;
    logic              div_wr;
    logic              store;
    logic              store_run;
    logic [1:0]        grp;
    logic [SLOT_W-1:0] fin_idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    kind_e kind;
    logic  cnt_zero;
    logic  div_done;
    logic  out_busy;
  } status_t;

  // Fold one sample into an entry: wrap sums, signed min/max, bump count
  function automatic entry_t add_sample(entry_t e, logic [STAT_W-1:0] total,
                                        logic [STAT_W-1:0] inner);
    logic [2:0][STAT_W-1:0] v;
    entry_t                 r;
    r    = e;
    v[0] = total;
    v[1] = inner;
    v[2] = total - inner;
    for (int g = 0; g < 3; g++) begin
      r.grp[g].sum_v = e.grp[g].sum_v + v[g];
      if ($signed(v[g]) < $signed(e.grp[g].min_v)) r.grp[g].min_v = v[g];
      if ($signed(v[g]) > $signed(e.grp[g].max_v)) r.grp[g].max_v = v[g];
    end
    r.cnt = e.cnt + CNT_W'(1);
    return r;
  endfunction

endpackage

### hdl/etst_div.sv
// ----------------------------------------------------------------------------
// etst_div
// Bit-serial signed divider: 64-bit signed sum by 32-bit unsigned count,
// truncating toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "event_timing_statistics_table_assert.svh"
module etst_div import etst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STAT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [STAT_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(STAT_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic              neg_q;
  logic [STAT_W-1:0] quo_q;
  logic [CNT_W-1:0]  rem_q, dsr_q;
  logic [CNT_W:0]    rem_sh;
  logic              fits;
  logic [CNT_W-1:0]  rem_nx;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[STAT_W-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    rem_nx = fits ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(STAT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[STAT_W-1];
      quo_q <= dividend_i[STAT_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[STAT_W-2:0], fits};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -quo_q : quo_q;

  `ETST_ASSERT_NOW(a_div_start_idle, start_i, !busy_q, "divider started while busy")
  `ETST_ASSERT_NEXT(a_div_done_last, busy_q && cnt_q == STEP_W'(1), done_q && !busy_q,
    "divider did not finish after last step")
  `ETST_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "divider done held")

endmodule

### hdl/etst_ctrl.sv
// ----------------------------------------------------------------------------
// etst_ctrl
// Controller: sequences event handling and the finalize walk over the run
// entry and every task row.
// ----------------------------------------------------------------------------
`include "event_timing_statistics_table_assert.svh"
module etst_ctrl import etst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [1:0]        grp_q, grp_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              frun_q, frun_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= '0;
      idx_q   <= '0;
      frun_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      idx_q   <= idx_d;
      frun_q  <= frun_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    grp_d         = grp_q;
    idx_d         = idx_q;
    frun_d        = frun_q;
    cmd_o         = '0;
    cmd_o.grp     = grp_q;
    cmd_o.fin_idx = idx_q;
    cmd_o.store_run = frun_q;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (status_i.kind == K_FINALIZE) begin
          cmd_o.ent_run = 1'b1;
          frun_d        = 1'b1;
          idx_d         = '0;
          grp_d         = '0;
          state_d       = S_FGRP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold a read while the previous result is still stalled
        if (!(status_i.kind == K_READ && status_i.out_busy)) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FGRP: begin
        if (status_i.cnt_zero) begin
          cmd_o.zero_min = 1'b1;
          if (grp_q == 2'd2) begin
            grp_d   = '0;
            state_d = S_FWB;
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          if (grp_q == 2'd2) begin
            grp_d   = '0;
            state_d = S_FWB;
          end else begin
            grp_d   = grp_q + 2'd1;
            state_d = S_FGRP;
          end
        end
      end
      S_FWB: begin
        cmd_o.store = 1'b1;
        if (frun_q) begin
          frun_d  = 1'b0;
          idx_d   = '0;
          state_d = S_FRD;
        end else if (idx_q == SLOT_W'(SLOT_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + SLOT_W'(1);
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_fin = 1'b1;
        state_d      = S_FLD;
      end
      S_FLD: begin
        cmd_o.ent_mem = 1'b1;
        state_d       = S_FGRP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `ETST_ASSERT_NEXT(a_ctrl_acc_read, in_valid_i && !in_stall_o, state_q == S_READ,
    "accepted transfer not followed by read step")
  `ETST_ASSERT_NOW(a_ctrl_grp_range, state_q == S_FGRP || state_q == S_FWAIT,
    grp_q != 2'd3, "finalize group out of range")
  `ETST_ASSERT_NEXT(a_ctrl_run_then_rows, state_q == S_FWB && frun_q,
    state_q == S_FRD && idx_q == '0, "finalize did not start rows at zero")

endmodule

### hdl/etst_dp.sv
// ----------------------------------------------------------------------------
// etst_dp
// Datapath: event registers, run statistics, worker stopwatches, task row
// memory with valid bits, finalize working entry, divider, result register.
// ----------------------------------------------------------------------------
`include "event_timing_statistics_table_assert.svh"
module etst_dp import etst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [WORKER_W-1:0]  worker_i,
  input  logic [SLOT_W-1:0]    task_slot_i,
  input  logic [TIME_BITS-1:0] now_ns_i,
  input  logic                 read_run_entry_i,
  input  logic                 out_stall_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  output entry_t               out_ent_o
);

  kind_e                kind_q;
  logic [WORKER_W-1:0]  worker_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 pick_q;

  entry_t               run_q;
  logic [TIME_BITS-1:0] run_base_q, phase_begin_q;
  logic [STAT_W-1:0]    phase_sum_q;
  logic [TIME_BITS-1:0] worker_base_q [WORKER_COUNT];

  row_t                 mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  row_t                 rd_row_q;
  logic                 rd_vld_q;
  logic [SLOT_W-1:0]    rd_addr;
  row_t                 view;

  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_wa;
  row_t                 mem_wd;

  entry_t               ent_q;
  entry_t               out_q;
  logic                 out_valid_q;

  logic [TIME_BITS-1:0] run_el, w_el;
  entry_t               run_end_ent, task_end_ent;
  logic                 div_done;
  logic [STAT_W-1:0]    div_quot;
  logic                 out_load;

  // Capture the event
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= kind_e'(kind_i);
      worker_q <= worker_i;
      slot_q   <= task_slot_i;
      now_q    <= now_ns_i;
      pick_q   <= read_run_entry_i;
    end
  end

  // Elapsed times and sample updates
  always_comb begin
    view         = rd_vld_q ? rd_row_q : ROW_RESET;
    run_el       = now_q - run_base_q;
    w_el         = now_q - worker_base_q[worker_q];
    run_end_ent  = add_sample(run_q, STAT_W'(run_el), phase_sum_q);
    task_end_ent = add_sample(view.ent, STAT_W'(w_el),
                              STAT_W'(view.ie) - STAT_W'(view.ib));
    rd_addr      = cmd_i.rd_fin ? cmd_i.fin_idx : slot_q;
    out_load     = cmd_i.exec && kind_q == K_READ;
  end

  // Select the row write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_q;
    mem_wd = view;
    if (cmd_i.store && !cmd_i.store_run) begin
      mem_we     = 1'b1;
      mem_wa     = cmd_i.fin_idx;
      mem_wd.ent = ent_q;
    end else if (cmd_i.exec) begin
      case (kind_q)
        K_INNER_BEGIN: begin
          mem_we    = 1'b1;
          mem_wd.ib = w_el;
        end
        K_INNER_END: begin
          mem_we    = 1'b1;
          mem_wd.ie = w_el;
        end
        K_TASK_END: begin
          mem_we     = 1'b1;
          mem_wd.ent = task_end_ent;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Task row memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_row_q <= mem_q[rd_addr];
  end

  // Row valid bits: a row not yet written reads as cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.exec && kind_q == K_CLEAR) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
      end
      if (cmd_i.rd_en) rd_vld_q <= valid_q[rd_addr];
    end
  end

  // Run entry, stopwatches and phase accounting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q         <= ENTRY_RESET;
      run_base_q    <= '0;
      phase_begin_q <= '0;
      phase_sum_q   <= '0;
      for (int w = 0; w < WORKER_COUNT; w++) worker_base_q[w] <= '0;
    end else if (cmd_i.store && cmd_i.store_run) begin
      run_q <= ent_q;
    end else if (cmd_i.exec) begin
      case (kind_q)
        K_CLEAR: begin
          run_q         <= ENTRY_RESET;
          phase_begin_q <= '0;
          phase_sum_q   <= '0;
        end
        K_RUN_BEGIN: begin
          run_base_q  <= now_q;
          phase_sum_q <= '0;
        end
        K_PHASE_BEGIN: phase_begin_q <= run_el;
        K_PHASE_END:   phase_sum_q <= phase_sum_q + STAT_W'(run_el) - STAT_W'(phase_begin_q);
        K_RUN_END:     run_q <= run_end_ent;
        K_TASK_BEGIN:  worker_base_q[worker_q] <= now_q;
        default: begin
          run_q <= run_q;
        end
      endcase
    end
  end

  // Finalize working entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_run) begin
      ent_q <= run_q;
    end else if (cmd_i.ent_mem) begin
      ent_q <= view.ent;
    end else if (cmd_i.zero_min) begin
      ent_q.grp[cmd_i.grp].min_v <= '0;
    end else if (cmd_i.div_wr) begin
      ent_q.grp[cmd_i.grp].sum_v <= div_quot;
    end
  end

  etst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (ent_q.grp[cmd_i.grp].sum_v),
    .divisor_i  (ent_q.cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= pick_q ? run_q : view.ent;
  end

  assign out_valid_o       = out_valid_q;
  assign out_ent_o         = out_q;
  assign status_o.kind     = kind_q;
  assign status_o.cnt_zero = ent_q.cnt == '0;
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  `ETST_ASSERT_NOW(a_dp_div_nonzero, cmd_i.div_start, ent_q.cnt != '0,
    "divide started with zero count")
  `ETST_ASSERT_NOW(a_dp_out_free, out_load, !(out_valid_q && out_stall_i),
    "result overwritten while stalled")
  `ETST_ASSERT_NOW(a_dp_one_writer, cmd_i.store, !cmd_i.exec,
    "finalize store collides with event update")

endmodule

### hdl/event_timing_statistics_table.sv
// ----------------------------------------------------------------------------
// event_timing_statistics_table
// Profiling monitor: sum/min/max/count of total, inner and overhead times
// for one run entry and 64 task entries, with finalize and readback.
// ----------------------------------------------------------------------------
// Sequencing: an ordinary event passes through accept, row read and update; a
// read puts its result in an output register, so the next event is accepted
// while that result waits. Finalize walks the run entry and all 64 task rows;
// each entry with a nonzero count spends three divisions, one per group, in
// the shared bit-serial divider, each with its start and done. Task rows sit
// in a single-port memory with one valid bit per row, so clear takes one
// event and no sweep after reset is needed.
module event_timing_statistics_table import etst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [WORKER_W-1:0]  worker_i,
  input  logic [SLOT_W-1:0]    task_slot_i,
  input  logic [TIME_BITS-1:0] now_ns_i,
  input  logic                 read_run_entry_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [63:0]   total_avg_o,
  output logic signed [63:0]   total_min_o,
  output logic signed [63:0]   total_max_o,
  output logic signed [63:0]   inner_avg_o,
  output logic signed [63:0]   inner_min_o,
  output logic signed [63:0]   inner_max_o,
  output logic signed [63:0]   overhead_avg_o,
  output logic signed [63:0]   overhead_min_o,
  output logic signed [63:0]   overhead_max_o,
  output logic [31:0]          sample_count_o
);

  cmd_t    cmd;
  status_t status;
  entry_t  out_ent;

  etst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  etst_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .worker_i         (worker_i),
    .task_slot_i      (task_slot_i),
    .now_ns_i         (now_ns_i),
    .read_run_entry_i (read_run_entry_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ent_o        (out_ent)
  );

  // Unpack the result entry
  assign total_avg_o    = $signed(out_ent.grp[0].sum_v);
  assign total_min_o    = $signed(out_ent.grp[0].min_v);
  assign total_max_o    = $signed(out_ent.grp[0].max_v);
  assign inner_avg_o    = $signed(out_ent.grp[1].sum_v);
  assign inner_min_o    = $signed(out_ent.grp[1].min_v);
  assign inner_max_o    = $signed(out_ent.grp[1].max_v);
  assign overhead_avg_o = $signed(out_ent.grp[2].sum_v);
  assign overhead_min_o = $signed(out_ent.grp[2].min_v);
  assign overhead_max_o = $signed(out_ent.grp[2].max_v);
  assign sample_count_o = out_ent.cnt;

endmodule
